// ===== design/msbb_pkg.sv =====
// shared constants, types and helpers for the msb-first bit string builder
// no dependencies; used by msbb_ram users, msbb_merge and msb_bit_string_builder

package msbb_pkg;

    // store geometry
    localparam int STORE_BYTES = 128;
    localparam int CAP_BITS    = STORE_BYTES * 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CUR_W       = $clog2(CAP_BITS + 1);

    // item field widths
    localparam int OP_W    = 3;
    localparam int VAL_W   = 64;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 7;
    localparam int POS_W   = 11;
    localparam int BYTE_W  = 8;

    // pending bit source: a coin word is a 4-bit length over up to 64 data bits
    localparam int SRC_W   = VAL_W + 4;
    localparam int REM_W   = 7;
    localparam int TAKE_W  = 4;
    localparam int OFF_W   = 3;

    // packed port widths
    localparam int S_DATA_W = ((VAL_W + CNT_W + IDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((POS_W + BYTE_W + 1 + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_WRITE  = 3'd1,
        OP_COINS  = 3'd2,
        OP_PAD    = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    // merge unit request and answer
    typedef struct packed {
        logic [BYTE_W-1:0] old_byte;
        logic [OFF_W-1:0]  off;
        logic [REM_W-1:0]  rem;
        logic [SRC_W-1:0]  src;
    } t_mrg_req;

    typedef struct packed {
        logic [BYTE_W-1:0] new_byte;
        logic [TAKE_W-1:0] take;
    } t_mrg_rsp;

    // number of significant bytes of a coin amount
    function automatic logic [3:0] coin_len(input logic [VAL_W-1:0] v);
        logic [3:0] len;
        len = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i*8 +: 8] != 8'd0) begin
                len = 4'(i + 1);
            end
        end
        return len;
    endfunction

    // coin word: length nibble directly above the significant bytes
    function automatic logic [SRC_W-1:0] coin_src(input logic [VAL_W-1:0] v,
                                                  input logic [3:0] len);
        logic [VAL_W-1:0] vmask;
        logic [6:0]       sh;
        sh    = {len, 3'b000};
        vmask = (len >= 4'd8) ? {VAL_W{1'b1}} : ((VAL_W'(1) << sh) - VAL_W'(1));
        return (SRC_W'(len) << sh) | SRC_W'(v & vmask);
    endfunction

endpackage

// ===== design/msbb_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module msbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/msbb_merge.sv =====
// byte merge unit: places the next bits of the pending source into one store byte
// depends on msbb_pkg

module msbb_merge (
    input  msbb_pkg::t_mrg_req i_req,
    output msbb_pkg::t_mrg_rsp o_rsp
);

    logic [msbb_pkg::TAKE_W-1:0] avail;
    logic [msbb_pkg::TAKE_W-1:0] take;
    logic [msbb_pkg::REM_W-1:0]  sh;
    logic [msbb_pkg::SRC_W-1:0]  shifted;
    logic [msbb_pkg::BYTE_W-1:0] tmask;
    logic [msbb_pkg::BYTE_W-1:0] chunk;
    logic [msbb_pkg::OFF_W-1:0]  pos;
    logic [msbb_pkg::BYTE_W-1:0] bmask;

    // bits that fit in this byte
    always_comb begin
        avail = msbb_pkg::TAKE_W'(8) - msbb_pkg::TAKE_W'(i_req.off);
        if (i_req.rem < msbb_pkg::REM_W'(avail)) begin
            take = msbb_pkg::TAKE_W'(i_req.rem);
        end else begin
            take = avail;
        end
    end

    // top take bits of the remaining string, zero above the source
    always_comb begin
        sh      = i_req.rem - msbb_pkg::REM_W'(take);
        shifted = i_req.src >> sh;
        tmask   = msbb_pkg::BYTE_W'((9'h1 << take) - 9'h1);
        chunk   = shifted[msbb_pkg::BYTE_W-1:0] & tmask;
    end

    // drop the chunk in below the already written bits
    always_comb begin
        pos            = msbb_pkg::OFF_W'(msbb_pkg::TAKE_W'(8) - msbb_pkg::TAKE_W'(i_req.off)
                                          - take);
        bmask          = tmask << pos;
        o_rsp.new_byte = (i_req.old_byte & ~bmask) | ((chunk << pos) & bmask);
        o_rsp.take     = take;
    end

endmodule

// ===== design/msb_bit_string_builder.sv =====
// msb-first bit string builder: byte store in ram, read-modify-write sequencer
// clear and unused ops go straight to done, read byte passes a readback state; a write, coin
// write or pad touching B store bytes does one ram read and one ram write per byte
// throughput: one word at a time, the next word is taken once the result is registered
// reset: synchronous active low, clears cursor, overflow flag and per-byte valid bits
// a store byte whose valid bit is clear reads as zero; clear op drops all valid bits at once

module msb_bit_string_builder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // value[63:0], bit_count[70:64], byte_index[77:71], zero fill
    input  logic [msbb_pkg::S_DATA_W-1:0] i_s_tdata,
    // op[2:0]
    input  logic [msbb_pkg::OP_W-1:0]     i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // bit_position[10:0], read_data[18:11], overflow[19], zero fill
    output logic [msbb_pkg::M_DATA_W-1:0] o_m_tdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_STEP  = 5'b00010,
        S_MERGE = 5'b00100,
        S_RDBK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [msbb_pkg::CUR_W-1:0]  r_cursor, n_cursor;
    logic                        r_ovf, n_ovf;
    logic [msbb_pkg::REM_W-1:0]  r_rem, n_rem;
    logic [msbb_pkg::SRC_W-1:0]  r_src, n_src;
    logic [msbb_pkg::BYTE_W-1:0] r_rd_data, n_rd_data;
    logic [msbb_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic                        r_rd_vld, n_rd_vld;
    logic [msbb_pkg::STORE_BYTES-1:0] r_valid, n_valid;
    logic                        r_m_valid, n_m_valid;
    logic [msbb_pkg::M_DATA_W-1:0] r_m_data, n_m_data;

    // input word fields
    msbb_pkg::t_op               in_op;
    logic [msbb_pkg::VAL_W-1:0]  in_value;
    logic [msbb_pkg::CNT_W-1:0]  in_count;
    logic [msbb_pkg::IDX_W-1:0]  in_index;
    logic                        in_acc;
    logic [3:0]                  clen;
    logic [msbb_pkg::OFF_W-1:0]  cur_off;

    // ram and merge hookup
    logic                        ram_we;
    logic [msbb_pkg::BYTE_W-1:0] ram_rdata;
    logic [msbb_pkg::ADDR_W-1:0] ram_raddr;
    logic [msbb_pkg::BYTE_W-1:0] old_byte;
    msbb_pkg::t_mrg_req          mrg_req;
    msbb_pkg::t_mrg_rsp          mrg_rsp;

    assign in_op    = msbb_pkg::t_op'(i_s_tuser);
    assign in_value = i_s_tdata[msbb_pkg::VAL_W-1:0];
    assign in_count = i_s_tdata[msbb_pkg::VAL_W +: msbb_pkg::CNT_W];
    assign in_index = i_s_tdata[msbb_pkg::VAL_W + msbb_pkg::CNT_W +: msbb_pkg::IDX_W];
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign clen     = msbb_pkg::coin_len(in_value);
    assign cur_off  = r_cursor[msbb_pkg::OFF_W-1:0];
    assign old_byte = r_rd_vld ? ram_rdata : '0;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // byte store
    msbb_ram #(
        .WIDTH (msbb_pkg::BYTE_W),
        .DEPTH (msbb_pkg::STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (mrg_rsp.new_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // bit placement into the fetched byte
    assign mrg_req.old_byte = old_byte;
    assign mrg_req.off      = cur_off;
    assign mrg_req.rem      = r_rem;
    assign mrg_req.src      = r_src;

    msbb_merge u_merge (
        .i_req (mrg_req),
        .o_rsp (mrg_rsp)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cursor  = r_cursor;
        n_ovf     = r_ovf;
        n_rem     = r_rem;
        n_src     = r_src;
        n_rd_data = r_rd_data;
        n_addr    = r_addr;
        n_rd_vld  = r_rd_vld;
        n_valid   = r_valid;
        ram_we    = 1'b0;
        ram_raddr = r_cursor[msbb_pkg::ADDR_W+2:3];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_rd_data = '0;
                    n_state   = S_DONE;
                    unique case (in_op)
                        msbb_pkg::OP_CLEAR: begin
                            n_cursor = '0;
                            n_ovf    = 1'b0;
                            n_valid  = '0;
                        end
                        msbb_pkg::OP_WRITE: begin
                            n_src   = msbb_pkg::SRC_W'(in_value);
                            n_rem   = msbb_pkg::REM_W'(in_count);
                            n_state = S_STEP;
                        end
                        msbb_pkg::OP_COINS: begin
                            n_src   = msbb_pkg::coin_src(in_value, clen);
                            n_rem   = msbb_pkg::REM_W'({clen, 3'b000}) + msbb_pkg::REM_W'(4);
                            n_state = S_STEP;
                        end
                        msbb_pkg::OP_PAD: begin
                            // a one, then zeros up to the byte boundary; nothing when already aligned
                            n_src   = msbb_pkg::SRC_W'(8'h80 >> cur_off);
                            n_rem   = (cur_off == '0) ? '0
                                    : msbb_pkg::REM_W'(4'd8 - msbb_pkg::TAKE_W'(cur_off));
                            n_state = S_STEP;
                        end
                        msbb_pkg::OP_READ: begin
                            if (32'(in_index) < msbb_pkg::STORE_BYTES) begin
                                ram_raddr = msbb_pkg::ADDR_W'(in_index);
                                n_rd_vld  = r_valid[msbb_pkg::ADDR_W'(in_index)];
                                n_state   = S_RDBK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_STEP: begin
                priority if (r_rem == '0) begin
                    n_state = S_DONE;
                end else if (32'(r_cursor) >= msbb_pkg::CAP_BITS) begin
                    // store full: remaining bits are dropped
                    n_ovf   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_addr   = r_cursor[msbb_pkg::ADDR_W+2:3];
                    n_rd_vld = r_valid[r_cursor[msbb_pkg::ADDR_W+2:3]];
                    n_state  = S_MERGE;
                end
            end
            S_MERGE: begin
                ram_we          = 1'b1;
                n_valid[r_addr] = 1'b1;
                n_cursor        = r_cursor + msbb_pkg::CUR_W'(mrg_rsp.take);
                n_rem           = r_rem - msbb_pkg::REM_W'(mrg_rsp.take);
                n_state         = S_STEP;
            end
            S_RDBK: begin
                n_rd_data = old_byte;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        if (r_state == S_DONE && (!r_m_valid || i_m_tready)) begin
            n_m_valid = 1'b1;
            n_m_data  = msbb_pkg::M_DATA_W'({r_ovf, r_rd_data,
                                              msbb_pkg::POS_W'(r_cursor)});
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cursor  <= '0;
            r_ovf     <= 1'b0;
            r_valid   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_ovf     <= n_ovf;
            r_valid   <= n_valid;
            r_m_valid <= n_m_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_src     <= n_src;
        r_rd_data <= n_rd_data;
        r_addr    <= n_addr;
        r_rd_vld  <= n_rd_vld;
        r_m_data  <= n_m_data;
    end

`ifndef ASSERT_OFF
    // cursor never runs past the store
    a_cursor_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cursor) <= msbb_pkg::CAP_BITS)
        else $error("bit cursor past store capacity");

    // overflow only comes up with the store full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> (32'(r_cursor) == msbb_pkg::CAP_BITS))
        else $error("overflow set with room left");

    // a merge always has bits to place and writes inside the store
    a_merge_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (r_rem != '0 && mrg_rsp.take != '0))
        else $error("merge step with nothing to write");

    // cursor only moves back on a clear taken in idle
    a_cursor_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_cursor >= $past(r_cursor)))
        else $error("bit cursor moved back during an op");
`endif

endmodule

// ===== tb/msbb_checker.sv =====
// result checker for the msb-first bit string builder: watches both stream channels,
// predicts each result word from the accepted input words and compares field by field
// depends on msbb_pkg for widths and op codes

module msbb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // value[63:0], bit_count[70:64], byte_index[77:71], zero fill
    input  logic [msbb_pkg::S_DATA_W-1:0] i_s_tdata,
    // op[2:0]
    input  logic [msbb_pkg::OP_W-1:0]     i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // bit_position[10:0], read_data[18:11], overflow[19], zero fill
    input  logic [msbb_pkg::M_DATA_W-1:0] i_m_tdata,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [msbb_pkg::POS_W-1:0]  pos;
        logic [msbb_pkg::BYTE_W-1:0] rd;
        logic                        ovf;
    } t_status;

    // shadow copy of the store, cursor and sticky overflow
    logic [msbb_pkg::BYTE_W-1:0] shadow_store [msbb_pkg::STORE_BYTES];
    int unsigned                 shadow_cursor;
    logic                        shadow_ovf;

    t_status expected_status_q[$];
    t_status got_status;
    t_status want_status;

    task automatic report_mismatch(input string msg);
        $display("checker: %s (t=%0t)", msg, $realtime);
        o_fail_count++;
    endtask

    function automatic void clear_shadow();
        foreach (shadow_store[i]) begin
            shadow_store[i] = '0;
        end
        shadow_cursor = 0;
        shadow_ovf    = 1'b0;
    endfunction

    // one bit at the cursor, msb of each byte first; dropped once the store is full
    function automatic void append_bit(input logic b);
        if (shadow_cursor >= msbb_pkg::CAP_BITS) begin
            shadow_ovf = 1'b1;
            return;
        end
        shadow_store[shadow_cursor / 8][7 - (shadow_cursor % 8)] = b;
        shadow_cursor++;
    endfunction

    // counts above 64 lead with zeros
    function automatic void append_bits(input logic [msbb_pkg::VAL_W-1:0] v, input int n);
        for (int k = n; k > 0; k--) begin
            append_bit((k - 1 < msbb_pkg::VAL_W) ? v[k-1] : 1'b0);
        end
    endfunction

    // length nibble, then the significant bytes high to low
    function automatic void append_coins(input logic [msbb_pkg::VAL_W-1:0] v);
        int                         len;
        logic [msbb_pkg::VAL_W-1:0] rest;
        len  = 0;
        rest = v;
        while (rest != '0 && len < 8) begin
            len++;
            rest = rest >> 8;
        end
        append_bits(msbb_pkg::VAL_W'(len), 4);
        for (int i = 0; i < len; i++) begin
            append_bits((v >> ((len - 1 - i) * 8)) & 64'hFF, 8);
        end
    endfunction

    // a one then zeros up to the byte boundary, nothing when aligned
    function automatic void pad_to_byte();
        int rem;
        rem = shadow_cursor % 8;
        if (rem == 0) begin
            return;
        end
        append_bit(1'b1);
        repeat (7 - rem) append_bit(1'b0);
    endfunction

    function automatic t_status predict_status(input logic [msbb_pkg::OP_W-1:0]  op_code,
                                               input logic [msbb_pkg::VAL_W-1:0] v,
                                               input logic [msbb_pkg::CNT_W-1:0] cnt,
                                               input logic [msbb_pkg::IDX_W-1:0] idx);
        t_status s;
        s.rd = '0;
        case (op_code)
            msbb_pkg::OP_CLEAR: clear_shadow();
            msbb_pkg::OP_WRITE: append_bits(v, cnt);
            msbb_pkg::OP_COINS: append_coins(v);
            msbb_pkg::OP_PAD:   pad_to_byte();
            msbb_pkg::OP_READ:  if (idx < msbb_pkg::STORE_BYTES) s.rd = shadow_store[idx];
            default:  ;
        endcase
        s.pos = msbb_pkg::POS_W'(shadow_cursor);
        s.ovf = shadow_ovf;
        return s;
    endfunction

    // result side first: no result can leave in the cycle its word is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_shadow();
            expected_status_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_status.pos = i_m_tdata[msbb_pkg::POS_W-1:0];
                got_status.rd  = i_m_tdata[msbb_pkg::POS_W +: msbb_pkg::BYTE_W];
                got_status.ovf = i_m_tdata[msbb_pkg::POS_W + msbb_pkg::BYTE_W];
                if (expected_status_q.size() == 0) begin
                    report_mismatch("result word with no expectation waiting");
                end else begin
                    want_status = expected_status_q.pop_front();
                    if (got_status.pos !== want_status.pos) begin
                        report_mismatch($sformatf("bit_position got %0d want %0d",
                                                  got_status.pos, want_status.pos));
                    end
                    if (got_status.rd !== want_status.rd) begin
                        report_mismatch($sformatf("read_data got %02h want %02h",
                                                  got_status.rd, want_status.rd));
                    end
                    if (got_status.ovf !== want_status.ovf) begin
                        report_mismatch($sformatf("overflow got %b want %b",
                                                  got_status.ovf, want_status.ovf));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_status_q.push_back(predict_status(
                    i_s_tuser,
                    i_s_tdata[msbb_pkg::VAL_W-1:0],
                    i_s_tdata[msbb_pkg::VAL_W +: msbb_pkg::CNT_W],
                    i_s_tdata[msbb_pkg::VAL_W + msbb_pkg::CNT_W +: msbb_pkg::IDX_W]));
            end
        end
        o_pending = expected_status_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// testbench top for msb_bit_string_builder: drives op words, stalls the result side,
// runs a watchdog and prints the verdict; checking is done in msbb_checker
// depends on msbb_pkg, msbb_checker and the design files

module tb;

    localparam int RANDOM_WORDS   = 1125;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    // op codes the block treats as no operation
    localparam logic [msbb_pkg::OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [msbb_pkg::OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [msbb_pkg::OP_W-1:0] OP_SPARE_HI  = 3'd7;

    logic                          i_clk    = 1'b0;
    logic                          i_rst_n  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic [msbb_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [msbb_pkg::OP_W-1:0]     s_tuser  = '0;
    logic                          m_tready = 1'b0;
    logic                          s_tready;
    logic                          m_tvalid;
    logic [msbb_pkg::M_DATA_W-1:0] m_tdata;
    int                            fail_count;
    int                            pending;
    int                            words_sent = 0;
    bit                            calm       = 1'b0;

    always #4 i_clk = ~i_clk;

    msb_bit_string_builder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    msbb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, a few long ones, none during calm stretches
    function automatic int gap_len();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [msbb_pkg::VAL_W-1:0] rand_value();
        return {$urandom(), $urandom()};
    endfunction

    // zero, exactly 64, above 64, small, anything
    function automatic logic [msbb_pkg::CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return msbb_pkg::CNT_W'(64);
            2:       return msbb_pkg::CNT_W'($urandom_range(65, 127));
            3, 4, 5: return msbb_pkg::CNT_W'($urandom_range(1, 16));
            default: return msbb_pkg::CNT_W'($urandom_range(0, 127));
        endcase
    endfunction

    // coin amounts spread over every significant-byte count
    function automatic logic [msbb_pkg::VAL_W-1:0] pick_coins();
        int shift;
        shift = $urandom_range(0, 8);
        if (shift == 8) begin
            return '0;
        end
        return rand_value() >> (8 * shift);
    endfunction

    function automatic logic [msbb_pkg::OP_W-1:0] pick_message_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return msbb_pkg::OP_WRITE;
        end else if (r < 70) begin
            return msbb_pkg::OP_COINS;
        end else if (r < 80) begin
            return msbb_pkg::OP_PAD;
        end
        return msbb_pkg::OP_READ;
    endfunction

    // any op code, spare ones included
    function automatic logic [msbb_pkg::OP_W-1:0] OP_OP_W_NOISE();
        if ($urandom_range(0, 3) == 0) begin
            return msbb_pkg::OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end
        return msbb_pkg::OP_W'($urandom_range(0, 7));
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [msbb_pkg::OP_W-1:0]  op_code,
                             input logic [msbb_pkg::VAL_W-1:0] v,
                             input logic [msbb_pkg::CNT_W-1:0] cnt,
                             input logic [msbb_pkg::IDX_W-1:0] idx);
        int                            gap;
        logic [msbb_pkg::S_DATA_W-1:0] word;
        gap  = gap_len();
        word = '0;
        word[msbb_pkg::VAL_W-1:0]                            = v;
        word[msbb_pkg::VAL_W +: msbb_pkg::CNT_W]             = cnt;
        word[msbb_pkg::VAL_W + msbb_pkg::CNT_W +: msbb_pkg::IDX_W] = idx;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tuser  <= op_code;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        words_sent++;
        @(negedge i_clk);
    endtask

    // other fields random, fields that matter shaped per op
    task automatic send_op(input logic [msbb_pkg::OP_W-1:0] op_code);
        logic [msbb_pkg::VAL_W-1:0] v;
        logic [msbb_pkg::CNT_W-1:0] cnt;
        v   = rand_value();
        cnt = msbb_pkg::CNT_W'($urandom_range(0, 127));
        if (op_code == msbb_pkg::OP_WRITE) begin
            cnt = pick_count();
        end
        if (op_code == msbb_pkg::OP_COINS) begin
            v = pick_coins();
        end
        send_word(op_code, v, cnt, msbb_pkg::IDX_W'($urandom_range(0, 127)));
    endtask

    // sender holds off until every result is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // result side stalls
    initial begin : result_stall
        int stall;
        @(negedge i_clk);
        forever begin
            stall = gap_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    // stretches without any idling
    initial begin : calm_toggle
        forever begin
            repeat ($urandom_range(100, 400)) @(posedge i_clk);
            calm <= ($urandom_range(0, 3) == 0);
        end
    end

    // ends the run when nothing moves on either channel for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int kind;
        int burst;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty store, field extremes, every op
        send_word(msbb_pkg::OP_READ, '0, '0, '0);
        send_word(msbb_pkg::OP_WRITE, '1, '0, '0);
        send_word(msbb_pkg::OP_WRITE, 64'd1, 7'd1, '0);
        send_word(msbb_pkg::OP_PAD, '0, '0, '0);
        send_word(msbb_pkg::OP_PAD, '0, '0, '0);
        send_word(msbb_pkg::OP_WRITE, '1, 7'd64, '0);
        send_word(msbb_pkg::OP_COINS, '0, '0, '0);
        send_word(msbb_pkg::OP_COINS, 64'h0100, '0, '0);
        send_word(msbb_pkg::OP_COINS, '1, '0, '0);
        send_word(msbb_pkg::OP_WRITE, 64'hA5C3_0F96_5A3C_F069, 7'd127, '0);
        send_word(msbb_pkg::OP_READ, '0, '0, 7'd1);
        send_word(msbb_pkg::OP_READ, '0, '0, 7'd2);
        send_word(OP_SPARE_LO, '1, '1, '1);
        send_word(OP_SPARE_MID, '1, '1, '1);
        send_word(OP_SPARE_HI, '0, '0, '0);
        // fill the store past capacity
        repeat (8) send_word(msbb_pkg::OP_WRITE, rand_value(), 7'd127, '0);
        send_word(msbb_pkg::OP_PAD, '0, '0, '0);
        send_word(msbb_pkg::OP_COINS, '1, '0, '0);
        send_word(msbb_pkg::OP_READ, '0, '0, 7'd127);
        send_word(msbb_pkg::OP_CLEAR, '1, '1, '1);
        send_word(msbb_pkg::OP_READ, '0, '0, 7'd127);
        wait_for_results();

        // random: message-like bursts with random content, some noise
        while (words_sent < RANDOM_WORDS + 25) begin
            kind = $urandom_range(0, 19);
            case (kind)
                0, 1: begin
                    send_op(msbb_pkg::OP_CLEAR);
                end
                10, 11, 12: begin
                    burst = $urandom_range(4, 12);
                    repeat (burst) send_word(msbb_pkg::OP_WRITE, rand_value(),
                                             msbb_pkg::CNT_W'($urandom_range(96, 127)),
                                             msbb_pkg::IDX_W'($urandom_range(0, 127)));
                end
                13, 14: begin
                    burst = $urandom_range(1, 6);
                    repeat (burst) send_op(msbb_pkg::OP_READ);
                end
                15, 16: begin
                    burst = $urandom_range(1, 4);
                    repeat (burst) send_op(OP_OP_W_NOISE());
                end
                17: begin
                    send_op(msbb_pkg::OP_PAD);
                    send_op(msbb_pkg::OP_READ);
                end
                18: begin
                    wait_for_results();
                end
                default: begin
                    burst = $urandom_range(2, 10);
                    repeat (burst) send_op(pick_message_op());
                end
            endcase
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
